// ===== rtl/core/hcc_pkg.sv =====
// Shared constants, types and helper functions for the cutter clearance block.
package hcc_pkg;

	// Default map size in cells along each axis
	localparam int GRID_DEF = 1024;

	// Sample window; the half window must be a power of two
	localparam int WINDOW     = 32;
	localparam int HALF_WIN   = WINDOW / 2;
	localparam int HALF_SHIFT = $clog2(HALF_WIN);
	localparam int WIN_W      = $clog2(WINDOW);

	// Field and register widths
	localparam int POS_W    = 16;
	localparam int HALF_W   = 15;
	localparam int SCALE_W  = 16;
	localparam int RADIUS_W = 15;
	localparam int HGT_W    = 15;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;

	// Mapping datapath widths (offsets carry the half-window factor)
	localparam int U_W        = POS_W + 2;
	localparam int US_W       = U_W + HALF_SHIFT + 1;
	localparam int LIM_W      = HALF_W + 1 + HALF_SHIFT;
	localparam int PROD_W     = LIM_W + SCALE_W;
	localparam int FRAC_SHIFT = 16 + HALF_SHIFT;
	localparam int PIX_W      = PROD_W - FRAC_SHIFT;

	// Scoring widths: excess is kept scaled by 2*h*h
	localparam int SQ_W       = 2 * HALF_SHIFT + 1;
	localparam int PEN_W      = SQ_W + 1;
	localparam int PENP_W     = RADIUS_W + PEN_W;
	localparam int DIFF_SHIFT = 2 * HALF_SHIFT + 1;
	localparam int BEST_W     = HGT_W + DIFF_SHIFT;
	localparam int DIFF_W     = BEST_W + 2;

	// Register reset values
	localparam logic [HALF_W-1:0]   HALF_WIDTH_RST  = 15'd1536;
	localparam logic [HALF_W-1:0]   HALF_HEIGHT_RST = 15'd1536;
	localparam logic [SCALE_W-1:0]  SCALE_X_RST     = 16'd21845;
	localparam logic [SCALE_W-1:0]  SCALE_Y_RST     = 16'd21845;
	localparam logic [RADIUS_W-1:0] RADIUS_RST      = 15'd164;

	// Register indexes (word address)
	localparam logic [2:0] REG_HALF_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HALF_HEIGHT = 3'd1;
	localparam logic [2:0] REG_SCALE_X     = 3'd2;
	localparam logic [2:0] REG_SCALE_Y     = 3'd3;
	localparam logic [2:0] REG_RADIUS      = 3'd4;

	// Item kinds
	localparam logic KIND_SPLAT = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Tag carried through the mapping unit
	typedef struct packed {
		logic             is_y;
		logic             last;
		logic [PEN_W-1:0] pen;
	} map_tag_t;

	// One heightmap sample on its way to scoring
	typedef struct packed {
		logic             valid;
		logic             ok;
		logic             last;
		logic [PEN_W-1:0] pen;
	} sample_t;

	// (k - h)^2 for a window index k
	function automatic logic [SQ_W-1:0] sq_off(input logic [WIN_W-1:0] k);
		logic [WIN_W:0]     d;
		logic [WIN_W:0]     m;
		logic [2*WIN_W+1:0] p;
		d = {1'b0, k} - (WIN_W+1)'(HALF_WIN);
		m = d[WIN_W] ? (~d + 1'b1) : d;
		p = m * m;
		return p[SQ_W-1:0];
	endfunction

endpackage

// ===== rtl/core/hcc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module hcc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/hcc_map.sv =====
// Shared world-to-cell mapping unit: range check, scale multiply, cell bound.
module hcc_map #(
	parameter int GRID = hcc_pkg::GRID_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	input  logic signed [hcc_pkg::US_W-1:0]   us,
	input  logic [hcc_pkg::LIM_W-1:0]         lim,
	input  logic [hcc_pkg::SCALE_W-1:0]       scale,
	input  hcc_pkg::map_tag_t                 tag,
	output logic                              rsp_valid,
	output logic [$clog2(GRID)-1:0]           pix,
	output logic                              ok,
	output hcc_pkg::map_tag_t                 rsp_tag
);

	import hcc_pkg::*;

	localparam int PW = $clog2(GRID);

	logic              valid_s1;
	logic              inr_s1;
	logic [PROD_W-1:0] prod_s1;
	map_tag_t          tag_s1;
	logic              inr;
	logic [PIX_W-1:0]  pix_full;

	// Negative or beyond 2*half lands off the map
	assign inr = (us[US_W-1:LIM_W] == '0) && (us[LIM_W-1:0] <= lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			valid_s1  <= req_valid;
			rsp_valid <= valid_s1;
		end
	end

	assign pix_full = prod_s1[PROD_W-1:FRAC_SHIFT];

	always_ff @(posedge clk) begin
		inr_s1  <= inr;
		prod_s1 <= us[LIM_W-1:0] * scale;
		tag_s1  <= tag;
		ok      <= inr_s1 && (pix_full < PIX_W'(GRID));
		pix     <= pix_full[PW-1:0];
		rsp_tag <= tag_s1;
	end

endmodule

// ===== rtl/core/hcc_score.sv =====
// Cutter excess scoring: penalty multiply, then running maximum over the window.
module hcc_score (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clr,
	input  hcc_pkg::sample_t               smp,
	input  logic [hcc_pkg::HGT_W-1:0]      rdata,
	input  logic [hcc_pkg::RADIUS_W-1:0]   radius,
	output logic                           done,
	output logic [hcc_pkg::BEST_W-1:0]     best
);

	import hcc_pkg::*;

	logic               valid_s4;
	logic               last_s4;
	logic [HGT_W-1:0]   zs_s4;
	logic [PENP_W-1:0]  pen_s4;
	logic signed [DIFF_W-1:0] diff;

	always_ff @(posedge clk) begin
		zs_s4  <= smp.ok ? rdata : '0;
		pen_s4 <= radius * smp.pen;
	end

	// height*2h^2 - r*((i-h)^2 + (j-h)^2)
	assign diff = $signed({2'b00, zs_s4, {DIFF_SHIFT{1'b0}}})
		- $signed({{(DIFF_W-PENP_W){1'b0}}, pen_s4});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			last_s4  <= 1'b0;
			done     <= 1'b0;
			best     <= '0;
		end else begin
			valid_s4 <= smp.valid;
			last_s4  <= smp.last;
			done     <= valid_s4 && last_s4;
			if (clr) begin
				best <= '0;
			end else if (valid_s4 && !diff[DIFF_W-1] && (diff[BEST_W-1:0] > best)) begin
				best <= diff[BEST_W-1:0];
			end
		end
	end

endmodule

// ===== rtl/core/heightmap_cutter_clearance.sv =====
// Top level: config registers, sample sequencer, heightmap memory, result register.
//
// Ball-end cutter clearance over a GRID x GRID heightmap of unsigned Q7.8 depth
// cells. Items come in on the item channel (valid/ready) and each gives exactly
// one result on the res channel (valid/ready). A splat (kind 0) maps a world
// point to a cell and raises the cell to the point depth if deeper; its result
// is clearance 0 and hit = point landed on the map. A query (kind 1) scans a
// 32 x 32 window around the point and returns the largest cutter excess.
// A splat maps x and then y; a query maps x once per row of the window and then
// one sample per cycle along the row, since all mapping goes through the single
// shared mapping unit and all samples through the one read port of the heightmap
// memory. One item is in work at a time; item_ready is high only while the
// sequencer is idle, from the cycle after the result is loaded, so no item is
// taken before the result of the last one is loaded. After reset all heightmap
// cells, 2^(2*clog2(GRID)) of them (1048576 at the default map size), are
// cleared one cell per cycle; no item is taken meanwhile, register writes are.
// The result sits in an output register, so a stalled receiver does not stop
// the next transaction from being accepted and worked on; only its result
// waits until the register frees.
// Registers are on an APB-style port at word addresses; pready is always high.
module heightmap_cutter_clearance #(
	parameter int GRID = hcc_pkg::GRID_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic                               kind,
	input  logic signed [hcc_pkg::POS_W-1:0]   pos_x,
	input  logic signed [hcc_pkg::POS_W-1:0]   pos_y,
	input  logic signed [hcc_pkg::POS_W-1:0]   depth,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic [hcc_pkg::HGT_W-1:0]          clearance,
	output logic                               hit,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [hcc_pkg::ADDR_W-1:0]         paddr,
	input  logic [hcc_pkg::DATA_W-1:0]         pwdata,
	output logic [hcc_pkg::DATA_W-1:0]         prdata,
	output logic                               pready
);

	import hcc_pkg::*;

	localparam int PW = $clog2(GRID);
	localparam int AW = 2 * PW;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_ISSUE = 3'd2;
	localparam logic [2:0] ST_WAIT  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	// Configuration
	logic [HALF_W-1:0]   half_width_q;
	logic [HALF_W-1:0]   half_height_q;
	logic [SCALE_W-1:0]  scale_x_q;
	logic [SCALE_W-1:0]  scale_y_q;
	logic [RADIUS_W-1:0] radius_q;
	logic                cfg_wr;

	// Sequencer
	logic [2:0]          state_q;
	logic [AW-1:0]       clr_addr_q;
	logic                kind_q;
	logic signed [POS_W-1:0] depth_q;
	logic signed [US_W-1:0]  usx_q;
	logic signed [US_W-1:0]  usy_q;
	logic signed [US_W-1:0]  usy_row_q;
	logic [WIN_W-1:0]    row_q;
	logic [WIN_W-1:0]    col_q;
	logic [WIN_W-1:0]    last_idx_q;
	logic                hdr_q;
	logic                accept;
	logic                col_end;
	logic                row_end;

	// Start offsets
	logic signed [U_W-1:0]  ux;
	logic signed [U_W-1:0]  uy;
	logic signed [US_W-1:0] base_x;
	logic signed [US_W-1:0] base_y;
	logic signed [US_W-1:0] roff;
	logic signed [US_W-1:0] rstep;
	logic [LIM_W-1:0]       lim_x;
	logic [LIM_W-1:0]       lim_y;

	// Mapping unit
	logic                   map_valid;
	logic signed [US_W-1:0] map_us;
	logic [LIM_W-1:0]       map_lim;
	logic [SCALE_W-1:0]     map_scale;
	map_tag_t               map_tag;
	logic                   rsp_valid;
	logic [PW-1:0]          rsp_pix;
	logic                   rsp_ok;
	map_tag_t               rsp_tag;

	// Memory and samples
	logic [PW-1:0]    px_q;
	logic             okx_q;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [HGT_W-1:0] rd_data;
	sample_t          smp_s3;
	sample_t          score_smp;
	logic [AW-1:0]    addr_s3;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [HGT_W-1:0] wr_data;
	logic             splat_deeper;
	logic             splat_done;
	logic             splat_hit_q;

	// Scoring and result
	logic              score_done;
	logic [BEST_W-1:0] best;
	logic              load_res;
	logic              res_valid_q;
	logic [HGT_W-1:0]  clearance_q;
	logic              hit_q;
	logic [HGT_W-1:0]  q_clear;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q  <= HALF_WIDTH_RST;
			half_height_q <= HALF_HEIGHT_RST;
			scale_x_q     <= SCALE_X_RST;
			scale_y_q     <= SCALE_Y_RST;
			radius_q      <= RADIUS_RST;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_HALF_WIDTH: begin
					half_width_q <= pwdata[HALF_W-1:0];
				end
				REG_HALF_HEIGHT: begin
					half_height_q <= pwdata[HALF_W-1:0];
				end
				REG_SCALE_X: begin
					scale_x_q <= pwdata[SCALE_W-1:0];
				end
				REG_SCALE_Y: begin
					scale_y_q <= pwdata[SCALE_W-1:0];
				end
				REG_RADIUS: begin
					radius_q <= pwdata[RADIUS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_HALF_WIDTH:  prdata = {{(DATA_W-HALF_W){1'b0}}, half_width_q};
			REG_HALF_HEIGHT: prdata = {{(DATA_W-HALF_W){1'b0}}, half_height_q};
			REG_SCALE_X:     prdata = {{(DATA_W-SCALE_W){1'b0}}, scale_x_q};
			REG_SCALE_Y:     prdata = {{(DATA_W-SCALE_W){1'b0}}, scale_y_q};
			REG_RADIUS:      prdata = {{(DATA_W-RADIUS_W){1'b0}}, radius_q};
			default:         prdata = '0;
		endcase
	end

	// ---------------- start values ----------------
	// All offsets are kept times h so a splat is a 1x1 window at offset zero
	assign ux = $signed({{(U_W-POS_W){pos_x[POS_W-1]}}, pos_x})
		+ $signed({{(U_W-HALF_W){1'b0}}, half_width_q});
	assign uy = $signed({{(U_W-POS_W){pos_y[POS_W-1]}}, pos_y})
		+ $signed({{(U_W-HALF_W){1'b0}}, half_height_q});
	assign base_x = {{(US_W-U_W-HALF_SHIFT){ux[U_W-1]}}, ux, {HALF_SHIFT{1'b0}}};
	assign base_y = {{(US_W-U_W-HALF_SHIFT){uy[U_W-1]}}, uy, {HALF_SHIFT{1'b0}}};
	assign roff   = (kind == KIND_QUERY)
		? {{(US_W-RADIUS_W-HALF_SHIFT){1'b0}}, radius_q, {HALF_SHIFT{1'b0}}} : '0;
	assign rstep  = {{(US_W-RADIUS_W){1'b0}}, radius_q};
	assign lim_x  = {half_width_q, {(HALF_SHIFT+1){1'b0}}};
	assign lim_y  = {half_height_q, {(HALF_SHIFT+1){1'b0}}};

	// ---------------- sequencer ----------------
	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign col_end    = (col_q == last_idx_q);
	assign row_end    = (row_q == last_idx_q);
	assign splat_done = smp_s3.valid && smp_s3.last && (kind_q == KIND_SPLAT);
	assign load_res   = (state_q == ST_DONE) && (!res_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			row_q      <= '0;
			col_q      <= '0;
			hdr_q      <= 1'b1;
			last_idx_q <= '0;
			kind_q     <= KIND_SPLAT;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == {AW{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						kind_q     <= kind;
						row_q      <= '0;
						col_q      <= '0;
						hdr_q      <= 1'b1;
						last_idx_q <= (kind == KIND_QUERY) ? WIN_W'(WINDOW - 1) : '0;
						state_q    <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (hdr_q) begin
						hdr_q <= 1'b0;
					end else if (col_end) begin
						col_q <= '0;
						hdr_q <= 1'b1;
						row_q <= row_q + 1'b1;
						if (row_end) begin
							state_q <= ST_WAIT;
						end
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (splat_done || (score_done && kind_q == KIND_QUERY)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_res) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Offset accumulators: y steps by r per sample, x steps by r per row
	always_ff @(posedge clk) begin
		if (accept) begin
			depth_q   <= depth;
			usx_q     <= base_x - roff;
			usy_row_q <= base_y - roff;
		end else if (state_q == ST_ISSUE) begin
			if (hdr_q) begin
				usy_q <= usy_row_q;
			end else begin
				usy_q <= usy_q + rstep;
				if (col_end) begin
					usx_q <= usx_q + rstep;
				end
			end
		end
	end

	// Row header maps x, then each sample maps y
	always_comb begin
		map_valid   = (state_q == ST_ISSUE);
		map_tag.pen = {1'b0, sq_off(row_q)} + {1'b0, sq_off(col_q)};
		if (hdr_q) begin
			map_us       = usx_q;
			map_lim      = lim_x;
			map_scale    = scale_x_q;
			map_tag.is_y = 1'b0;
			map_tag.last = 1'b0;
		end else begin
			map_us       = usy_q;
			map_lim      = lim_y;
			map_scale    = scale_y_q;
			map_tag.is_y = 1'b1;
			map_tag.last = col_end && row_end;
		end
	end

	hcc_map #(
		.GRID(GRID)
	) u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(map_valid),
		.us       (map_us),
		.lim      (map_lim),
		.scale    (map_scale),
		.tag      (map_tag),
		.rsp_valid(rsp_valid),
		.pix      (rsp_pix),
		.ok       (rsp_ok),
		.rsp_tag  (rsp_tag)
	);

	// ---------------- heightmap access ----------------
	assign rd_en   = rsp_valid && rsp_tag.is_y;
	assign rd_addr = {rsp_pix, px_q};

	always_ff @(posedge clk) begin
		if (rsp_valid && !rsp_tag.is_y) begin
			px_q  <= rsp_pix;
			okx_q <= rsp_ok;
		end
		addr_s3 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_s3      <= '0;
			splat_hit_q <= 1'b0;
		end else begin
			smp_s3.valid <= rd_en;
			smp_s3.ok    <= rsp_ok && okx_q;
			smp_s3.last  <= rsp_tag.last;
			smp_s3.pen   <= rsp_tag.pen;
			if (splat_done) begin
				splat_hit_q <= smp_s3.ok;
			end
		end
	end

	assign splat_deeper = depth_q > $signed({1'b0, rd_data});

	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else begin
			wr_en   = splat_done && smp_s3.ok && splat_deeper;
			wr_addr = addr_s3;
			wr_data = depth_q[HGT_W-1:0];
		end
	end

	hcc_ram #(
		.WIDTH(HGT_W),
		.DEPTH(1 << AW)
	) u_cells (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// ---------------- scoring ----------------
	always_comb begin
		score_smp       = smp_s3;
		score_smp.valid = smp_s3.valid && (kind_q == KIND_QUERY);
	end

	hcc_score u_score (
		.clk   (clk),
		.arst_n(arst_n),
		.clr   (accept),
		.smp   (score_smp),
		.rdata (rd_data),
		.radius(radius_q),
		.done  (score_done),
		.best  (best)
	);

	// ---------------- result register ----------------
	assign q_clear = best[BEST_W-1:DIFF_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			if (kind_q == KIND_QUERY) begin
				clearance_q <= q_clear;
				hit_q       <= |q_clear;
			end else begin
				clearance_q <= '0;
				hit_q       <= splat_hit_q;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign clearance = clearance_q;
	assign hit       = hit_q;

endmodule

// ===== rtl/core/hcc_checker.sv =====
// Port-level assertions for the cutter clearance block, bound to the top level.
module hcc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      item_valid,
	input logic                      item_ready,
	input logic                      res_valid,
	input logic                      res_ready,
	input logic [hcc_pkg::HGT_W-1:0] clearance,
	input logic                      hit
);

	// Stalled result holds its value
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(clearance) && $stable(hit))
		else $error("result changed while stalled");

	// No hit means no lift, for splats and queries alike
	a_hit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !hit |-> clearance == '0)
		else $error("clearance without hit");

	// One transaction in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("ready right after accept");

	// A new result is loaded only from the busy sequencer
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!item_ready))
		else $error("result appeared while idle");

endmodule

bind heightmap_cutter_clearance hcc_checker u_hcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.item_valid(item_valid),
	.item_ready(item_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.clearance (clearance),
	.hit       (hit)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the heightmap cutter clearance block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import hcc_pkg::*;

	localparam int MAP_N = GRID_DEF;
	localparam int DEN = 2 * HALF_WIN * HALF_WIN;
	localparam logic [2:0] REG_UNUSED = 3'd5;

	typedef struct {
		logic               kind;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] depth;
	} cut_item_t;

	typedef struct {
		logic [HGT_W-1:0] clearance;
		logic             hit;
	} clear_res_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     item_valid = 1'b0;
	logic                     item_ready;
	logic                     kind = 1'b0;
	logic signed [POS_W-1:0]  pos_x = '0;
	logic signed [POS_W-1:0]  pos_y = '0;
	logic signed [POS_W-1:0]  depth = '0;
	logic                     res_valid;
	logic                     res_ready = 1'b0;
	logic [HGT_W-1:0]         clearance;
	logic                     hit;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [ADDR_W-1:0]        paddr = '0;
	logic [DATA_W-1:0]        pwdata = '0;
	logic [DATA_W-1:0]        prdata;
	logic                     pready;

	heightmap_cutter_clearance i_dut (.*);

	always #5 clk = ~clk;

	// shadow copy of the block's map and registers
	bit [HGT_W-1:0] depth_map [MAP_N*MAP_N];
	int cfg_half_w = HALF_WIDTH_RST;
	int cfg_half_h = HALF_HEIGHT_RST;
	int cfg_scale_x = SCALE_X_RST;
	int cfg_scale_y = SCALE_Y_RST;
	int cfg_radius = RADIUS_RST;

	cut_item_t  pending_items[$];
	clear_res_t expected_results[$];
	cut_item_t  cur_item;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int n_queued = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_landed = 0;
	int n_lifted = 0;
	int n_settings = 1;

	// world coordinate (scaled by hw) to cell index along one axis
	function automatic bit to_cell(input longint us, input longint hw, input longint half,
			input longint scale, output int pix);
		longint p;
		pix = 0;
		if (us < 0 || us > 2 * half * hw)
			return 1'b0;
		p = (us * scale) / (hw * 65536);
		if (p >= MAP_N)
			return 1'b0;
		pix = int'(p);
		return 1'b1;
	endfunction

	function automatic clear_res_t predict_result(input cut_item_t it);
		clear_res_t res;
		longint best, diff, zs, bx, by, di, dj, r, d;
		int px, py, i, j;
		bit okx, oky;
		res.clearance = '0;
		res.hit = 1'b0;
		if (it.kind == KIND_SPLAT) begin
			d = longint'(it.depth);
			okx = to_cell(longint'(it.pos_x) + cfg_half_w, 1, cfg_half_w, cfg_scale_x, px);
			oky = to_cell(longint'(it.pos_y) + cfg_half_h, 1, cfg_half_h, cfg_scale_y, py);
			if (okx && oky) begin
				if (d > longint'(depth_map[py*MAP_N + px]))
					depth_map[py*MAP_N + px] = it.depth[HGT_W-1:0];
				res.hit = 1'b1;
				n_landed++;
			end
		end else begin
			best = 0;
			r = cfg_radius;
			bx = (longint'(it.pos_x) + cfg_half_w) * HALF_WIN;
			by = (longint'(it.pos_y) + cfg_half_h) * HALF_WIN;
			for (i = 0; i < WINDOW; i++) begin
				di = i - HALF_WIN;
				okx = to_cell(bx + di * r, HALF_WIN, cfg_half_w, cfg_scale_x, px);
				for (j = 0; j < WINDOW; j++) begin
					dj = j - HALF_WIN;
					zs = 0;
					if (okx) begin
						oky = to_cell(by + dj * r, HALF_WIN, cfg_half_h, cfg_scale_y, py);
						if (oky)
							zs = depth_map[py*MAP_N + px];
					end
					diff = zs * DEN - r * (di * di + dj * dj);
					if (diff > best)
						best = diff;
				end
			end
			best = best / DEN;
			if (best > 32767)
				best = 32767;
			res.clearance = best[HGT_W-1:0];
			res.hit = (best > 0);
			if (res.hit)
				n_lifted++;
		end
		return res;
	endfunction

	// driver: one transaction in flight on the item channel
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready)
				expected_results.insert(expected_results.size(), predict_result(cur_item));
			if (!item_valid || item_ready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_item = pending_items.pop_front();
					item_valid <= 1'b1;
					kind <= cur_item.kind;
					pos_x <= cur_item.pos_x;
					pos_y <= cur_item.pos_y;
					depth <= cur_item.depth;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		res_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor
	always @(posedge clk) begin : res_check
		clear_res_t head;
		if (arst_n && res_valid && res_ready) begin
			if (expected_results.size() == 0) begin
				$error("result with no transaction pending: clearance %0d hit %0b",
					clearance, hit);
				n_errors++;
			end else begin
				head = expected_results.pop_front();
				if (clearance !== head.clearance) begin
					$error("clearance: expected %0d, actual %0d", head.clearance, clearance);
					n_errors++;
				end
				if (hit !== head.hit) begin
					$error("hit: expected %0b, actual %0b", head.hit, hit);
					n_errors++;
				end
				n_checked++;
			end
		end
	end

	task automatic queue_item(input logic k, input int x, input int y, input int d);
		cut_item_t it;
		it.kind = k;
		it.pos_x = 16'(x);
		it.pos_y = 16'(y);
		it.depth = 16'(d);
		pending_items.insert(pending_items.size(), it);
		n_queued++;
	endtask

	task automatic wait_idle();
		while (n_checked != n_queued)
			@(posedge clk);
	endtask

	task automatic read_reg(input logic [2:0] idx, input logic [31:0] want);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			$error("register %0d: expected 0x%0h, actual 0x%0h", idx, want, prdata);
			n_errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		logic [31:0] kept;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		kept = '0;
		case (idx)
			REG_HALF_WIDTH: begin
				kept = 32'(val[HALF_W-1:0]);
				cfg_half_w = int'(kept);
			end
			REG_HALF_HEIGHT: begin
				kept = 32'(val[HALF_W-1:0]);
				cfg_half_h = int'(kept);
			end
			REG_SCALE_X: begin
				kept = 32'(val[SCALE_W-1:0]);
				cfg_scale_x = int'(kept);
			end
			REG_SCALE_Y: begin
				kept = 32'(val[SCALE_W-1:0]);
				cfg_scale_y = int'(kept);
			end
			REG_RADIUS: begin
				kept = 32'(val[RADIUS_W-1:0]);
				cfg_radius = int'(kept);
			end
			default: ;
		endcase
		if (idx <= REG_RADIUS)
			read_reg(idx, kept);
	endtask

	// garbage above each register's width must be dropped
	task automatic set_config(input int hw, input int hh, input int sx, input int sy,
			input int r);
		write_reg(REG_HALF_WIDTH, ($urandom << HALF_W) | hw);
		write_reg(REG_HALF_HEIGHT, ($urandom << HALF_W) | hh);
		write_reg(REG_SCALE_X, ($urandom << SCALE_W) | sx);
		write_reg(REG_SCALE_Y, ($urandom << SCALE_W) | sy);
		write_reg(REG_RADIUS, ($urandom << RADIUS_W) | r);
		n_settings++;
	endtask

	function automatic int pick_on_map(input int half, input int scale);
		longint umax;
		umax = 2 * half;
		if (scale != 0 && (longint'(MAP_N) * 65536 - 1) / scale < umax)
			umax = (longint'(MAP_N) * 65536 - 1) / scale;
		return int'($urandom_range(int'(umax), 0)) - half;
	endfunction

	// mostly splat clusters on the query's sample lattice, then a query there
	task automatic gen_items(input int n);
		int made, cx, cy, nspl, ox, oy, d, k;
		made = 0;
		while (made < n) begin
			if ($urandom_range(99) < 70) begin
				cx = pick_on_map(cfg_half_w, cfg_scale_x);
				cy = pick_on_map(cfg_half_h, cfg_scale_y);
				nspl = $urandom_range(6, 2);
				for (k = 0; k < nspl; k++) begin
					ox = (int'($urandom_range(31)) - HALF_WIN) * cfg_radius / HALF_WIN;
					oy = (int'($urandom_range(31)) - HALF_WIN) * cfg_radius / HALF_WIN;
					if ($urandom_range(9) == 0)
						ox += int'($urandom_range(4)) - 2;
					d = ($urandom_range(9) == 0) ? -int'($urandom_range(32768))
						: int'($urandom_range(32767));
					queue_item(KIND_SPLAT, cx + ox, cy + oy, d);
				end
				if ($urandom_range(3) == 0) begin
					cx += int'($urandom_range(8)) - 4;
					cy += int'($urandom_range(8)) - 4;
				end
				queue_item(KIND_QUERY, cx, cy, $urandom);
				made += nspl + 1;
			end else begin
				queue_item(($urandom_range(3) == 0) ? KIND_QUERY : KIND_SPLAT,
					$urandom, $urandom, $urandom);
				made++;
			end
		end
	endtask

	task automatic run_phase(input int hw, input int hh, input int sx, input int sy,
			input int r, input int n, input int idle_s, input int idle_r);
		wait_idle();
		set_config(hw, hh, sx, sy, r);
		send_idle_pct = idle_s;
		recv_stall_pct = idle_r;
		gen_items(n);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		read_reg(REG_HALF_WIDTH, 32'(HALF_WIDTH_RST));
		read_reg(REG_HALF_HEIGHT, 32'(HALF_HEIGHT_RST));
		read_reg(REG_SCALE_X, 32'(SCALE_X_RST));
		read_reg(REG_SCALE_Y, 32'(SCALE_Y_RST));
		read_reg(REG_RADIUS, 32'(RADIUS_RST));

		// reset settings: map edges, deeper / shallower / negative splats, off-map
		queue_item(KIND_SPLAT, 0, 0, 1000);
		queue_item(KIND_SPLAT, 0, 0, 500);
		queue_item(KIND_SPLAT, 0, 0, -5);
		queue_item(KIND_SPLAT, -1536, -1536, 32767);
		queue_item(KIND_SPLAT, 1536, 1536, 32767);
		queue_item(KIND_SPLAT, 1537, 0, 700);
		queue_item(KIND_SPLAT, -1537, 0, 700);
		queue_item(KIND_SPLAT, 32767, -32768, -32768);
		queue_item(KIND_QUERY, 0, 0, 0);
		queue_item(KIND_QUERY, -1536, -1536, -1);
		queue_item(KIND_QUERY, 1536, 1536, 32767);
		queue_item(KIND_QUERY, 32767, 32767, 0);
		queue_item(KIND_QUERY, -32768, -32768, -32768);
		wait_idle();

		// pixel landing exactly on GRID, zero scale on y, flat cutter
		set_config(1024, 1536, 32768, 0, 0);
		queue_item(KIND_SPLAT, 1024, 100, 200);
		queue_item(KIND_SPLAT, 1023, 100, 300);
		queue_item(KIND_SPLAT, -1024, -1536, 400);
		queue_item(KIND_SPLAT, 1023, -1536, 32767);
		queue_item(KIND_QUERY, 1023, 500, 0);
		queue_item(KIND_QUERY, 1024, 0, 0);
		queue_item(KIND_QUERY, -1024, 1536, 0);
		queue_item(KIND_QUERY, -1025, 0, 0);

		run_phase(HALF_WIDTH_RST, HALF_HEIGHT_RST, SCALE_X_RST, SCALE_Y_RST, RADIUS_RST,
			100, 0, 0);
		run_phase(1536, 1536, 21845, 21845, 40, 50, 53, 0);
		// sender holds off until the block has drained
		wait_idle();
		gen_items(50);
		run_phase(32767, 32767, 512, 512, 32767, 80, 0, 53);
		run_phase(0, 32767, 0, 65535, 1, 60, 34, 34);
		run_phase(1024, 700, 32768, 40000, 800, 80, 53, 0);
		wait_idle();
		write_reg(REG_UNUSED, $urandom);
		run_phase($urandom_range(32767), $urandom_range(32767), $urandom_range(65535),
			$urandom_range(65535), $urandom_range(32767, 1), 80, 0, 53);
		run_phase($urandom_range(32767), $urandom_range(32767), $urandom_range(65535),
			$urandom_range(65535), $urandom_range(32767, 1), 80, 34, 34);

		wait_idle();
		repeat (1100) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			n_errors++;
		end
		$display("ran %0d transactions over %0d register settings", n_queued, n_settings);
		$display("%0d splats landed on the map, %0d queries needed lift", n_landed, n_lifted);
		if (n_errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// covers the post-reset map clear plus every transaction at its slowest
	initial begin
		#100_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule
